// ===== sv/fbpc_pkg.sv =====
// -----------------------------------------------------------------------------
// fbpc_pkg: shared constants and types for the frustum cull core
// Field widths, word layout, action codes and controller/datapath links.
// -----------------------------------------------------------------------------
`default_nettype none

package fbpc_pkg;

   localparam int PLANE_COUNT    = 5;
   localparam int COORD_BITS     = 24;
   localparam int NORMAL_BITS    = 16;
   localparam int OFFSET_BITS    = COORD_BITS + 2;
   localparam int NORMAL_FRAC    = NORMAL_BITS - 2;
   localparam int SEL_BITS       = 3;
   localparam int ACTION_BITS    = 2;
   localparam int PROD_BITS      = NORMAL_BITS + COORD_BITS;
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int PLANE_IDX_BITS = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int CNT_BITS       = $clog2(PLANE_COUNT + 1);

   // req_tdata layout, lowest bit first
   localparam int POS_SEL    = 0;
   localparam int POS_NX     = POS_SEL + SEL_BITS;
   localparam int POS_NY     = POS_NX + NORMAL_BITS;
   localparam int POS_NZ     = POS_NY + NORMAL_BITS;
   localparam int POS_OFF    = POS_NZ + NORMAL_BITS;
   localparam int POS_MIN_X  = POS_OFF + OFFSET_BITS;
   localparam int POS_MIN_Y  = POS_MIN_X + COORD_BITS;
   localparam int POS_MIN_Z  = POS_MIN_Y + COORD_BITS;
   localparam int POS_MAX_X  = POS_MIN_Z + COORD_BITS;
   localparam int POS_MAX_Y  = POS_MAX_X + COORD_BITS;
   localparam int POS_MAX_Z  = POS_MAX_Y + COORD_BITS;
   localparam int REQ_FIELD_BITS = POS_MAX_Z + COORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 8;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_WRITE = 2'd0,
      ACT_BOX   = 2'd1,
      ACT_POINT = 2'd2
   } action_type;

   typedef logic signed [COORD_BITS-1:0]  coord_type;
   typedef logic signed [NORMAL_BITS-1:0] normal_type;
   typedef logic signed [OFFSET_BITS-1:0] offset_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic [PLANE_IDX_BITS-1:0]     plane_idx_type;
   typedef logic [CNT_BITS-1:0]           plane_cnt_type;

   typedef struct packed {
      logic          capture;   // take the input word
      logic          issue;     // run one plane through the dot-product unit
      plane_idx_type idx;
      logic          load_rsp;  // load result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic          in_test;   // incoming word is a box or point test
      plane_cnt_type in_count;  // planes the incoming test checks
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/fbpc_ctrl.sv =====
// -----------------------------------------------------------------------------
// fbpc_ctrl: sequencer for the frustum cull core
// Takes a word, steps the plane index for tests, owns the output handshake.
// -----------------------------------------------------------------------------
`default_nettype none

module fbpc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire fbpc_pkg::dp_status_type status,
   output fbpc_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   fbpc_pkg::plane_idx_type idx_ff, idx_in;
   fbpc_pkg::plane_cnt_type count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    last_plane;

   assign last_plane = (fbpc_pkg::CNT_BITS'(idx_ff) + fbpc_pkg::CNT_BITS'(1)) == count_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      cmd.idx      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               count_in    = status.in_count;
               if (status.in_test) begin
                  state_in = (status.in_count == '0) ? ST_DONE : ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cmd.issue = 1'b1;
            if (last_plane) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + fbpc_pkg::PLANE_IDX_BITS'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/fbpc_dp.sv =====
// -----------------------------------------------------------------------------
// fbpc_dp: plane store and dot-product datapath
// Holds the planes, picks the p-vertex, one plane per cycle through three
// multipliers, then a sum of the registered products and a registered sign check.
// -----------------------------------------------------------------------------
`default_nettype none

module fbpc_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [fbpc_pkg::ACTION_BITS-1:0]     req_tuser,
   input  wire logic [fbpc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire fbpc_pkg::ctrl_cmd_type               cmd,
   output fbpc_pkg::dp_status_type                   status,
   output logic [fbpc_pkg::RSP_DATA_BITS-1:0]        rsp_tdata
);

   localparam int PC = fbpc_pkg::PLANE_COUNT;

   logic [fbpc_pkg::SEL_BITS-1:0] in_sel;
   logic [fbpc_pkg::SEL_BITS:0]   in_sel_wide;
   fbpc_pkg::normal_type          in_n   [3];
   fbpc_pkg::coord_type           in_lo  [3];
   fbpc_pkg::coord_type           in_hi  [3];
   fbpc_pkg::offset_type          in_off;
   logic [2:0]                    in_corner;
   logic                          in_write;

   fbpc_pkg::normal_type  normal_ff [PC][3];
   fbpc_pkg::offset_type  offset_ff [PC];
   logic [2:0]            corner_ff [PC];

   fbpc_pkg::coord_type   lo_ff [3];
   fbpc_pkg::coord_type   hi_ff [3];
   logic                  point_ff;

   fbpc_pkg::prod_type    prod_ff [3];
   fbpc_pkg::prod_type    prod_in [3];
   fbpc_pkg::prod_type    offterm_ff, offterm_in;
   logic                  prod_valid_ff;
   logic                  reject_ff, reject_in;
   logic                  inside_ff;
   fbpc_pkg::acc_type     acc;
   logic [2:0]            use_min;

   assign in_sel      = req_tdata[fbpc_pkg::POS_SEL +: fbpc_pkg::SEL_BITS];
   assign in_sel_wide = {1'b0, in_sel};
   assign in_n[0]     = req_tdata[fbpc_pkg::POS_NX +: fbpc_pkg::NORMAL_BITS];
   assign in_n[1]     = req_tdata[fbpc_pkg::POS_NY +: fbpc_pkg::NORMAL_BITS];
   assign in_n[2]     = req_tdata[fbpc_pkg::POS_NZ +: fbpc_pkg::NORMAL_BITS];
   assign in_off      = req_tdata[fbpc_pkg::POS_OFF +: fbpc_pkg::OFFSET_BITS];
   assign in_lo[0]    = req_tdata[fbpc_pkg::POS_MIN_X +: fbpc_pkg::COORD_BITS];
   assign in_lo[1]    = req_tdata[fbpc_pkg::POS_MIN_Y +: fbpc_pkg::COORD_BITS];
   assign in_lo[2]    = req_tdata[fbpc_pkg::POS_MIN_Z +: fbpc_pkg::COORD_BITS];
   assign in_hi[0]    = req_tdata[fbpc_pkg::POS_MAX_X +: fbpc_pkg::COORD_BITS];
   assign in_hi[1]    = req_tdata[fbpc_pkg::POS_MAX_Y +: fbpc_pkg::COORD_BITS];
   assign in_hi[2]    = req_tdata[fbpc_pkg::POS_MAX_Z +: fbpc_pkg::COORD_BITS];
   // bit 2 x, bit 1 y, bit 0 z: negative normal faces the box minimum
   assign in_corner   = {in_n[0][fbpc_pkg::NORMAL_BITS-1],
                         in_n[1][fbpc_pkg::NORMAL_BITS-1],
                         in_n[2][fbpc_pkg::NORMAL_BITS-1]};
   assign in_write    = cmd.capture && (req_tuser == fbpc_pkg::ACT_WRITE) &&
                        (in_sel_wide < (fbpc_pkg::SEL_BITS + 1)'(PC));

   always_comb begin
      status = '0;
      unique case (req_tuser)
         fbpc_pkg::ACT_BOX: begin
            status.in_test = 1'b1;
            if (in_sel_wide > (fbpc_pkg::SEL_BITS + 1)'(PC)) begin
               status.in_count = fbpc_pkg::CNT_BITS'(PC);
            end else begin
               status.in_count = fbpc_pkg::CNT_BITS'(in_sel);
            end
         end
         fbpc_pkg::ACT_POINT: begin
            status.in_test  = 1'b1;
            status.in_count = fbpc_pkg::CNT_BITS'(PC);
         end
         default: begin
            status = '0;
         end
      endcase
   end

   // multiply stage
   always_comb begin
      use_min = point_ff ? 3'b111 : corner_ff[cmd.idx];
      for (int a = 0; a < 3; a++) begin
         prod_in[a] = fbpc_pkg::PROD_BITS'(normal_ff[cmd.idx][a]) *
                      fbpc_pkg::PROD_BITS'(use_min[2-a] ? lo_ff[a] : hi_ff[a]);
      end
      offterm_in = {offset_ff[cmd.idx], {fbpc_pkg::NORMAL_FRAC{1'b0}}};
   end

   // sum stage
   assign acc = fbpc_pkg::ACC_BITS'(prod_ff[0]) + fbpc_pkg::ACC_BITS'(prod_ff[1]) +
                fbpc_pkg::ACC_BITS'(prod_ff[2]) - fbpc_pkg::ACC_BITS'(offterm_ff);
   assign reject_in = reject_ff | (prod_valid_ff & acc[fbpc_pkg::ACC_BITS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PC; k++) begin
            normal_ff[k][0] <= '0;
            normal_ff[k][1] <= '0;
            normal_ff[k][2] <= '0;
            offset_ff[k]    <= '0;
            corner_ff[k]    <= '0;
         end
         prod_valid_ff <= 1'b0;
         reject_ff     <= 1'b0;
      end else begin
         if (in_write) begin
            normal_ff[in_sel[fbpc_pkg::PLANE_IDX_BITS-1:0]][0] <= in_n[0];
            normal_ff[in_sel[fbpc_pkg::PLANE_IDX_BITS-1:0]][1] <= in_n[1];
            normal_ff[in_sel[fbpc_pkg::PLANE_IDX_BITS-1:0]][2] <= in_n[2];
            offset_ff[in_sel[fbpc_pkg::PLANE_IDX_BITS-1:0]]    <= in_off;
            corner_ff[in_sel[fbpc_pkg::PLANE_IDX_BITS-1:0]]    <= in_corner;
         end
         prod_valid_ff <= cmd.issue;
         reject_ff     <= cmd.capture ? 1'b0 : reject_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff    <= in_lo;
         hi_ff    <= in_hi;
         point_ff <= (req_tuser == fbpc_pkg::ACT_POINT);
      end
      if (cmd.issue) begin
         prod_ff    <= prod_in;
         offterm_ff <= offterm_in;
      end
      if (cmd.load_rsp) begin
         inside_ff <= ~reject_in;
      end
   end

   assign rsp_tdata = {{(fbpc_pkg::RSP_DATA_BITS - 1){1'b0}}, inside_ff};

endmodule

`default_nettype wire

// ===== sv/frustum_box_point_cull_core.sv =====
// -----------------------------------------------------------------------------
// frustum_box_point_cull_core: box and point culling against clip planes
// Plane write: no result word; the core stays ready for the next word.
// Box/point test over N planes (N = 5 for points): one plane per cycle through
// the shared three-multiplier dot-product unit; the result word is loaded in
// the done state and the next word is taken back in idle (held in the done
// state while an earlier result word is still waiting on the output).
// Reset (synchronous): all planes zero, so every test reports inside; the
// output register is emptied.
// -----------------------------------------------------------------------------
`default_nettype none

module frustum_box_point_cull_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // plane_select, normal_x, normal_y, normal_z, plane_offset,
   // min_x, min_y, min_z, max_x, max_y, max_z, zero pad
   input  wire logic [fbpc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // action
   input  wire logic [fbpc_pkg::ACTION_BITS-1:0]    req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // inside_res, zero pad
   output logic [fbpc_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   fbpc_pkg::ctrl_cmd_type  cmd;
   fbpc_pkg::dp_status_type status;

   fbpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fbpc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== sv/fbpc_check.sv =====
// -----------------------------------------------------------------------------
// fbpc_check: port-level checks for the frustum cull core
// Output handshake rules and word-flow properties, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module fbpc_check (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [fbpc_pkg::ACTION_BITS-1:0]   req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [fbpc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic test_word;
   logic write_word;

   assign test_word  = req_tvalid && req_tready &&
                       (req_tuser == fbpc_pkg::ACT_BOX || req_tuser == fbpc_pkg::ACT_POINT);
   assign write_word = req_tvalid && req_tready && (req_tuser == fbpc_pkg::ACT_WRITE);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      write_word && !rsp_tvalid |=> !rsp_tvalid)
      else $error("plane write produced a result word");

   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      test_word |=> !req_tready)
      else $error("test word did not occupy the core");

endmodule

bind frustum_box_point_cull_core fbpc_check u_fbpc_check (.*);

`default_nettype wire
